FILE: rtl/dscl_pkg.sv
// Shared types and constants for the copy/insert delta instruction counter.
// No dependencies; imported by dscl_core and the top level.
`default_nettype none

package dscl_pkg;

  // Result status codes as they appear on the status port.
  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_TOO_SHORT = 3'd1,
    ST_TRUNCATED = 3'd2,
    ST_MISMATCH  = 3'd3,
    ST_OVERFLOW  = 3'd4
  } status_e;

  // One result word, as produced by the core at the end of a stream.
  typedef struct packed {
    status_e     status;
    logic [31:0] source_copied;
    logic [31:0] inserted_count;
  } result_t;

  // Reset value of the shortest accepted stream length.
  localparam logic [7:0] MinLenReset = 8'd4;

  // Copy size used when both size bytes are absent or zero.
  localparam logic [16:0] CopySizeDefault = 17'h10000;

endpackage

`default_nettype wire

FILE: rtl/delta_stream_copy_literal_counter.sv
// Top level of the copy/insert delta instruction counter: handshakes, input
// and result registers, configuration register. Depends on dscl_pkg, dscl_core.
`default_nettype none

//  Channel  | Direction | Handshake               | Payload
//  ---------+-----------+-------------------------+--------------------------------
//  input    | in        | in_valid_i/in_stall_o   | delta_byte_i, last_byte_i
//  result   | out       | out_valid_o/out_stall_i | status_o, source_copied_o,
//           |           |                         | inserted_count_o
//  config   | in        | cfg_we_i                | cfg_wdata_i (min_delta_length)
//
// A word is accepted at a clock edge where its valid is high and its stall is low.
// Each accepted byte is held in the input register and parsed from there; the
// byte marked last loads its result word into the result register when it is
// parsed, and the word waits there until it is taken.
// One byte per cycle is sustained while no last byte is held back.
// Only a last byte can be held back, and only while the previous result word is
// still waiting on a stalled output; ordinary bytes keep flowing meanwhile.
// Reset clears the parser and sets the shortest accepted length to 4 bytes.
module delta_stream_copy_literal_counter #(
  parameter int COUNT_WIDTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_wdata_i,
  // Input words
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  delta_byte_i,
  input  logic        last_byte_i,
  // Result words
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  status_o,
  output logic [31:0] source_copied_o,
  output logic [31:0] inserted_count_o
);
  import dscl_pkg::*;

  logic [7:0] min_len_q;

  // Input register.
  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic       in_last_q;

  // Result register.
  logic       out_valid_q;
  result_t    out_q;
  result_t    core_result;

  logic       in_accept;
  logic       step;
  logic       out_take;

  // The held byte moves on unless it would end a stream while the previous
  // result word is still blocked downstream.
  assign step       = in_valid_q && !(in_last_q && out_valid_q && out_stall_i);
  assign in_stall_o = in_valid_q && !step;
  assign in_accept  = in_valid_i && !in_stall_o;
  assign out_take   = out_valid_q && !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_len_q <= MinLenReset;
    end else if (cfg_we_i) begin
      min_len_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_accept) begin
      in_valid_q <= 1'b1;
    end else if (step) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_byte_q <= delta_byte_i;
      in_last_q <= last_byte_i;
    end
  end

  dscl_core #(
    .CountWidth (COUNT_WIDTH)
  ) u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (step),
    .byte_i    (in_byte_q),
    .last_i    (in_last_q),
    .min_len_i (min_len_q),
    .result_o  (core_result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step && in_last_q) begin
      out_valid_q <= 1'b1;
    end else if (out_take) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && in_last_q) begin
      out_q <= core_result;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = out_q.status;
  assign source_copied_o  = out_q.source_copied;
  assign inserted_count_o = out_q.inserted_count;

  // Input is only held back while a byte already waits in the input register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> in_valid_q && in_last_q)
    else $error("top: input stalled without a held last byte");

  // Parsing a last byte always presents a result word next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    step && in_last_q |=> out_valid_q)
    else $error("top: end of stream produced no result word");

  // Counts are only reported for a clean stream.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.status != ST_OK |->
      out_q.source_copied == 32'd0 && out_q.inserted_count == 32'd0)
    else $error("top: counts reported with an error status");

  // A waiting result word is never overwritten.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_stall_i |-> !(step && in_last_q))
    else $error("top: result word overwritten while stalled");

endmodule

`default_nettype wire

FILE: rtl/dscl_core.sv
// Parser state and counters for the copy/insert delta instruction counter.
// Depends on dscl_pkg for the status codes and the result word.
`default_nettype none

module dscl_core #(
  parameter int CountWidth = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  logic [7:0]        byte_i,
  input  logic              last_i,
  input  logic [7:0]        min_len_i,
  output dscl_pkg::result_t result_o
);
  import dscl_pkg::*;

  // Width of the target size shifter: seven payload bits moved up to 63 places.
  localparam int ShW = 71;

  typedef enum logic [4:0] {
    PH_SRC_HDR   = 5'b00001,
    PH_DST_HDR   = 5'b00010,
    PH_CMD       = 5'b00100,
    PH_COPY_ARGS = 5'b01000,
    PH_LITERAL   = 5'b10000
  } phase_e;

  phase_e                  phase_q, phase_d;
  logic [5:0]              shift_q, shift_d;
  logic [CountWidth-1:0]   target_q, target_d;
  logic [6:0]              mask_q, mask_d;
  logic [15:0]             copy_len_q, copy_len_d;
  logic [6:0]              lit_rem_q, lit_rem_d;
  logic [CountWidth-1:0]   out_tot_q, out_tot_d;
  logic [CountWidth-1:0]   cop_tot_q, cop_tot_d;
  logic [CountWidth-1:0]   lit_tot_q, lit_tot_d;
  logic [31:0]             seen_q, seen_d;
  logic                    ovf_q, ovf_d;

  logic [ShW-1:0]          tgt_shifted;
  logic [5:0]              due;
  logic [5:0]              due_bit;
  logic                    copy_fin;
  logic                    lit_cmd;
  logic [16:0]             add_val;
  logic [CountWidth:0]     out_sum, cop_sum, lit_sum;
  logic [CountWidth+31:0]  cop_ext, lit_ext;
  status_e                 status;

  assign tgt_shifted = ShW'(byte_i[6:0]) << shift_q;
  assign due         = mask_q[5:0];
  assign due_bit     = due & (~due + 6'd1);

  always_comb begin
    phase_d    = phase_q;
    shift_d    = shift_q;
    target_d   = target_q;
    mask_d     = mask_q;
    copy_len_d = copy_len_q;
    lit_rem_d  = lit_rem_q;
    ovf_d      = ovf_q;
    copy_fin   = 1'b0;
    lit_cmd    = 1'b0;

    case (phase_q)
      PH_SRC_HDR: begin
        if (!byte_i[7]) phase_d = PH_DST_HDR;
      end
      PH_DST_HDR: begin
        // Payload bits that land at or above the counter width are lost.
        if (|tgt_shifted[ShW-1:CountWidth]) ovf_d = 1'b1;
        target_d = target_q | tgt_shifted[CountWidth-1:0];
        shift_d  = (shift_q >= 6'd57) ? 6'd63 : shift_q + 6'd7;
        if (!byte_i[7]) phase_d = PH_CMD;
      end
      PH_CMD: begin
        if (byte_i[7]) begin
          mask_d     = byte_i[6:0];
          copy_len_d = '0;
          if (|byte_i[5:0]) phase_d = PH_COPY_ARGS;
          else              copy_fin = 1'b1;
        end else begin
          lit_cmd   = 1'b1;
          lit_rem_d = byte_i[6:0];
          if (|byte_i[6:0]) phase_d = PH_LITERAL;
        end
      end
      PH_COPY_ARGS: begin
        // Operand bytes arrive in mask order, lowest bit first.
        if (due_bit[4]) copy_len_d[7:0]  = copy_len_q[7:0] | byte_i;
        if (due_bit[5]) copy_len_d[15:8] = copy_len_q[15:8] | byte_i;
        mask_d = mask_q & ~{1'b0, due_bit};
        if (mask_d[5:0] == 6'd0) copy_fin = 1'b1;
      end
      PH_LITERAL: begin
        if (lit_rem_q != 7'd0) lit_rem_d = lit_rem_q - 7'd1;
        if (lit_rem_d == 7'd0) phase_d = PH_CMD;
      end
      default: begin
        phase_d = PH_CMD;
      end
    endcase

    // One shared addend per byte: a finished copy size or a literal length.
    if (copy_fin) begin
      add_val = (copy_len_d == 16'd0) ? CopySizeDefault : {1'b0, copy_len_d};
    end else begin
      add_val = {9'd0, byte_i};
    end

    out_sum = {1'b0, out_tot_q} + (CountWidth+1)'(add_val);
    cop_sum = {1'b0, cop_tot_q} + (CountWidth+1)'(add_val);
    lit_sum = {1'b0, lit_tot_q} + (CountWidth+1)'(add_val);

    out_tot_d = out_tot_q;
    cop_tot_d = cop_tot_q;
    lit_tot_d = lit_tot_q;
    if (copy_fin || lit_cmd) begin
      out_tot_d = out_sum[CountWidth-1:0];
      if (out_sum[CountWidth]) ovf_d = 1'b1;
    end
    if (copy_fin && !mask_d[6]) begin
      cop_tot_d = cop_sum[CountWidth-1:0];
      if (cop_sum[CountWidth]) ovf_d = 1'b1;
    end
    if (lit_cmd) begin
      lit_tot_d = lit_sum[CountWidth-1:0];
      if (lit_sum[CountWidth]) ovf_d = 1'b1;
    end
    if (copy_fin) begin
      mask_d     = '0;
      copy_len_d = '0;
      phase_d    = PH_CMD;
    end

    seen_d = (seen_q == 32'hFFFF_FFFF) ? seen_q : seen_q + 32'd1;

    if (seen_d < {24'd0, min_len_i}) begin
      status = ST_TOO_SHORT;
    end else if (phase_d != PH_CMD) begin
      status = ST_TRUNCATED;
    end else if (ovf_d) begin
      status = ST_OVERFLOW;
    end else if (out_tot_d != target_d) begin
      status = ST_MISMATCH;
    end else begin
      status = ST_OK;
    end
  end

  assign cop_ext = {32'd0, cop_tot_d};
  assign lit_ext = {32'd0, lit_tot_d};

  always_comb begin
    result_o.status         = status;
    result_o.source_copied  = (status == ST_OK) ? cop_ext[31:0] : 32'd0;
    result_o.inserted_count = (status == ST_OK) ? lit_ext[31:0] : 32'd0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_SRC_HDR;
      shift_q    <= '0;
      target_q   <= '0;
      mask_q     <= '0;
      copy_len_q <= '0;
      lit_rem_q  <= '0;
      out_tot_q  <= '0;
      cop_tot_q  <= '0;
      lit_tot_q  <= '0;
      seen_q     <= '0;
      ovf_q      <= 1'b0;
    end else if (step_i) begin
      if (last_i) begin
        phase_q    <= PH_SRC_HDR;
        shift_q    <= '0;
        target_q   <= '0;
        mask_q     <= '0;
        copy_len_q <= '0;
        lit_rem_q  <= '0;
        out_tot_q  <= '0;
        cop_tot_q  <= '0;
        lit_tot_q  <= '0;
        seen_q     <= '0;
        ovf_q      <= 1'b0;
      end else begin
        phase_q    <= phase_d;
        shift_q    <= shift_d;
        target_q   <= target_d;
        mask_q     <= mask_d;
        copy_len_q <= copy_len_d;
        lit_rem_q  <= lit_rem_d;
        out_tot_q  <= out_tot_d;
        cop_tot_q  <= cop_tot_d;
        lit_tot_q  <= lit_tot_d;
        seen_q     <= seen_d;
        ovf_q      <= ovf_d;
      end
    end
  end

  // A fresh stream has seen no bytes and still waits for its source header.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    seen_q == 32'd0 |-> phase_q == PH_SRC_HDR)
    else $error("dscl_core: parser left the header phase without a byte");

  // A partial copy size only exists while copy operands are being read.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    copy_len_q != 16'd0 |-> phase_q == PH_COPY_ARGS)
    else $error("dscl_core: copy size held outside the operand phase");

  // Literal data still due only while skipping literal bytes.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    lit_rem_q != 7'd0 |-> phase_q == PH_LITERAL)
    else $error("dscl_core: literal count held outside the literal phase");

endmodule

`default_nettype wire

FILE: bench/tb.sv
// Self-checking bench for delta_stream_copy_literal_counter: it drives delta byte streams,
// predicts each end-of-stream result word and checks it field by field.
// Depends on dscl_pkg and the RTL top level only.
module tb;
  import dscl_pkg::*;

  localparam int CountWidth = 32;
  localparam logic [63:0] CountMask = {64{1'b1}} >> (64 - CountWidth);
  // Cycles with no accepted word before the run is declared hung.
  localparam int QuietLimit = 2000;
  // Idle cycles after the last result before a register write.
  localparam int SettleCycles = 4;
  // Once this few words remain, both sides stop idling.
  localparam int CalmTail = 150;
  localparam int ReportLimit = 10;
  // Cycles to wait once no result word is owed any more.
  localparam int DrainCycles = 8;
  // Operand mask bits of a copy command that carry the copy size.
  localparam logic [5:0] SizeLowDue = 6'h10;
  localparam logic [5:0] SizeHighDue = 6'h20;
  localparam int FromTargetBit = 6;

  // Where the parser stands inside the stream.
  typedef enum logic [2:0] {
    SCAN_SOURCE_SIZE,
    SCAN_TARGET_SIZE,
    SCAN_COMMAND,
    SCAN_COPY_OPERANDS,
    SCAN_LITERAL_DATA
  } scan_phase_e;

  // What the driver does with one entry of its queue: send a byte, write the
  // register once the block is idle, or merely wait until it is idle.
  typedef enum logic [1:0] {
    WORD_BYTE,
    WORD_CONFIG,
    WORD_DRAIN
  } stim_kind_e;

  typedef struct packed {
    stim_kind_e kind;
    logic [7:0] data;
    logic       last;
  } stim_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [7:0]  cfg_wdata_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [7:0]  delta_byte_i = '0;
  logic        last_byte_i = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [2:0]  status_o;
  logic [31:0] source_copied_o;
  logic [31:0] inserted_count_o;

  delta_stream_copy_literal_counter #(
    .COUNT_WIDTH(CountWidth)
  ) i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .delta_byte_i    (delta_byte_i),
    .last_byte_i     (last_byte_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .status_o        (status_o),
    .source_copied_o (source_copied_o),
    .inserted_count_o(inserted_count_o)
  );

  // Bench copy of the parser state and of the one configuration register.
  logic [7:0]            min_length;
  scan_phase_e           scan_phase;
  int                    size_shift;
  logic [63:0]           target_size;
  logic [6:0]            operand_mask;
  logic [16:0]           copy_size;
  logic [6:0]            literal_left;
  logic [CountWidth-1:0] output_bytes;
  logic [CountWidth-1:0] copied_bytes;
  logic [CountWidth-1:0] literal_bytes;
  logic [31:0]           bytes_seen;
  logic                  count_overflow;

  // Result words still owed by the block, oldest first.
  result_t expected_results[$];
  // Words waiting to be sent, filled once at time zero.
  stim_t   pending[$];
  int      bytes_queued = 0;
  logic [7:0] body_q[$];
  logic [7:0] stream_q[$];

  int   error_count = 0;
  logic in_taken = 1'b0;
  bit   idling_allowed = 1'b1;
  int   send_gap = 0;
  int   stall_left = 0;
  int   settle = 0;

  task automatic clear_scan;
    scan_phase     = SCAN_SOURCE_SIZE;
    size_shift     = 0;
    target_size    = '0;
    operand_mask   = '0;
    copy_size      = '0;
    literal_left   = '0;
    output_bytes   = '0;
    copied_bytes   = '0;
    literal_bytes  = '0;
    bytes_seen     = '0;
    count_overflow = 1'b0;
  endtask

  // Counters keep their low bits when a sum does not fit, and the overflow
  // is remembered until the end of the stream.
  task automatic add_count(inout logic [CountWidth-1:0] acc, input logic [16:0] amount);
    logic [CountWidth:0] sum;
    sum = {1'b0, acc} + (CountWidth+1)'(amount);
    if (sum[CountWidth]) count_overflow = 1'b1;
    acc = sum[CountWidth-1:0];
  endtask

  // A copy is complete: a size of zero stands for 64 KiB. Copies out of the
  // target itself add to the output but not to the source total.
  task automatic close_copy;
    logic [16:0] amount;
    amount = (copy_size == '0) ? CopySizeDefault : copy_size;
    if (!operand_mask[FromTargetBit]) add_count(copied_bytes, amount);
    add_count(output_bytes, amount);
    operand_mask = '0;
    copy_size    = '0;
    scan_phase   = SCAN_COMMAND;
  endtask

  // One 7-bit group of the target size. Bits pushed past 64 or past the
  // counter width flag an overflow; the shift sticks at 63.
  task automatic add_target_group(input logic [7:0] b);
    logic [63:0] group;
    logic [63:0] placed;
    group = {57'd0, b[6:0]};
    if (group != '0) begin
      placed = group << size_shift;
      if ((placed >> size_shift) != group) count_overflow = 1'b1;
      target_size = target_size | placed;
      if ((target_size & ~CountMask) != '0) begin
        count_overflow = 1'b1;
        target_size    = target_size & CountMask;
      end
    end
    size_shift = (size_shift + 7 > 63) ? 63 : size_shift + 7;
  endtask

  task automatic scan_byte(input logic [7:0] b);
    logic [5:0] due;
    logic [5:0] lowest;
    case (scan_phase)
      SCAN_SOURCE_SIZE: begin
        if (!b[7]) scan_phase = SCAN_TARGET_SIZE;
      end
      SCAN_TARGET_SIZE: begin
        add_target_group(b);
        if (!b[7]) scan_phase = SCAN_COMMAND;
      end
      SCAN_COMMAND: begin
        if (b[7]) begin
          operand_mask = b[6:0];
          copy_size    = '0;
          if (b[5:0] != '0) scan_phase = SCAN_COPY_OPERANDS;
          else close_copy();
        end else begin
          // A zero command byte is a literal of length zero.
          add_count(literal_bytes, {9'd0, b});
          add_count(output_bytes, {9'd0, b});
          literal_left = b[6:0];
          if (b != '0) scan_phase = SCAN_LITERAL_DATA;
        end
      end
      SCAN_COPY_OPERANDS: begin
        // Operands arrive in mask bit order; offsets are skipped.
        due    = operand_mask[5:0];
        lowest = due & (~due + 6'd1);
        if (lowest == SizeLowDue) copy_size[7:0] = copy_size[7:0] | b;
        else if (lowest == SizeHighDue) copy_size[15:8] = copy_size[15:8] | b;
        operand_mask[5:0] = due & ~lowest;
        if (operand_mask[5:0] == '0) close_copy();
      end
      SCAN_LITERAL_DATA: begin
        if (literal_left != '0) literal_left = literal_left - 7'd1;
        if (literal_left == '0) scan_phase = SCAN_COMMAND;
      end
      default: scan_phase = SCAN_COMMAND;
    endcase
  endtask

  // Accepted byte: update the bench state, and on the last byte of a stream
  // queue the result word the block owes, then start over.
  task automatic predict_word(input logic [7:0] b, input logic last);
    result_t r;
    if (bytes_seen != '1) bytes_seen = bytes_seen + 32'd1;
    scan_byte(b);
    if (last) begin
      if (bytes_seen < {24'd0, min_length}) r.status = ST_TOO_SHORT;
      else if (scan_phase != SCAN_COMMAND) r.status = ST_TRUNCATED;
      else if (count_overflow) r.status = ST_OVERFLOW;
      else if (64'(output_bytes) != target_size) r.status = ST_MISMATCH;
      else r.status = ST_OK;
      r.source_copied  = (r.status == ST_OK) ? 32'(copied_bytes) : '0;
      r.inserted_count = (r.status == ST_OK) ? 32'(literal_bytes) : '0;
      expected_results.push_back(r);
      clear_scan();
    end
  endtask

  task automatic queue_word(input stim_kind_e kind, input logic [7:0] data, input logic last);
    stim_t w;
    w.kind = kind;
    w.data = data;
    w.last = last;
    pending.push_back(w);
    if (kind == WORD_BYTE) bytes_queued++;
  endtask

  task automatic queue_byte(input logic [7:0] b, input logic last);
    queue_word(WORD_BYTE, b, last);
  endtask

  function automatic int varint_groups(input logic [63:0] v);
    int n;
    n = 1;
    while (v > 64'd127) begin
      v = v >> 7;
      n++;
    end
    return n;
  endfunction

  // Little-endian base-128 encoding; more groups than needed pad with zeros.
  task automatic put_varint(input logic [63:0] value, input int groups);
    for (int i = 0; i < groups; i++) begin
      stream_q.push_back({(i < groups - 1), value[6:0]});
      value = value >> 7;
    end
  endtask

  // A random command list with random content; total is its output size.
  task automatic build_body(output logic [63:0] total);
    int          len;
    logic [7:0]  cmd;
    logic [7:0]  opnd;
    logic [16:0] copy_len;
    body_q.delete();
    total = '0;
    repeat ($urandom_range(5, 1)) begin
      if ($urandom_range(1, 0) == 0) begin
        cmd = {1'b1, 7'($urandom_range(127, 0))};
        body_q.push_back(cmd);
        copy_len = '0;
        for (int bit_i = 0; bit_i < 6; bit_i++) begin
          if (cmd[bit_i]) begin
            opnd = 8'($urandom_range(255, 0));
            if (bit_i == 5 && $urandom_range(1, 0) == 0) opnd = '0;
            if (bit_i == 4) copy_len[7:0] = opnd;
            if (bit_i == 5) copy_len[15:8] = opnd;
            body_q.push_back(opnd);
          end
        end
        total = total + ((copy_len == '0) ? 64'(CopySizeDefault) : 64'(copy_len));
      end else begin
        // Long literals are rare so that streams stay short and results frequent.
        len = ($urandom_range(11, 0) == 0) ? $urandom_range(127, 0) : $urandom_range(8, 0);
        body_q.push_back(8'(len));
        repeat (len) body_q.push_back(8'($urandom_range(255, 0)));
        total = total + 64'(len);
      end
    end
  endtask

  // One random stream. Most are well formed; the rest carry a wrong or too
  // wide target size, an over-long size encoding, a cut, or are pure noise.
  task automatic queue_random_stream;
    int          pick;
    int          cut;
    int          groups;
    logic [63:0] total;
    logic [63:0] target;
    logic [63:0] src;
    pick = $urandom_range(99, 0);
    stream_q.delete();
    if (pick < 12) begin
      repeat ($urandom_range(12, 1)) stream_q.push_back(8'($urandom_range(255, 0)));
    end else begin
      build_body(total);
      target = total;
      groups = varint_groups(total);
      if (pick < 20) begin
        target = (total != '0 && $urandom_range(1, 0) == 1) ? total - 64'd1
                                                           : total + 64'($urandom_range(3, 1));
        groups = varint_groups(target);
      end else if (pick < 25) begin
        target = total + (64'($urandom_range(255, 1)) << CountWidth);
        groups = varint_groups(target);
      end else if (pick < 30) begin
        // Padded size: extra zero groups, which may run the shift into its ceiling.
        groups = groups + $urandom_range(8, 1);
      end
      src = ($urandom_range(3, 0) == 0) ? 64'($urandom) : 64'($urandom_range(200, 0));
      put_varint(src, varint_groups(src));
      put_varint(target, groups);
      foreach (body_q[i]) stream_q.push_back(body_q[i]);
      if (pick >= 30 && pick < 42) begin
        cut = $urandom_range(stream_q.size() - 1, 1);
        while (stream_q.size() > cut) void'(stream_q.pop_back());
      end
    end
    foreach (stream_q[i]) queue_byte(stream_q[i], i == stream_q.size() - 1);
  endtask

  // Free-running clock, period 20.
  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // Reset is asserted from time zero and released on a falling edge.
  initial begin
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
  end

  // The monitor samples both channels and the register port at the rising
  // edge, before the block's own updates for that edge take effect.
  always @(posedge clk_i) begin : monitor
    result_t want;
    in_taken <= rst_ni && in_valid_i && !in_stall_o;
    idling_allowed <= pending.size() > CalmTail;
    if (rst_ni) begin
      if (cfg_we_i) min_length = cfg_wdata_i;
      if (in_valid_i && !in_stall_o) predict_word(delta_byte_i, last_byte_i);
      if (out_valid_o && !out_stall_i) begin
        if (expected_results.size() == 0) begin
          error_count++;
          if (error_count <= ReportLimit) begin
            $display("unexpected result word: status %0d copied %0d literal %0d",
                     status_o, source_copied_o, inserted_count_o);
          end
        end else begin
          want = expected_results.pop_front();
          if (status_o !== want.status || source_copied_o !== want.source_copied ||
              inserted_count_o !== want.inserted_count) begin
            error_count++;
            if (error_count <= ReportLimit) begin
              $display("result mismatch: expected status %0d copied %0d literal %0d",
                       want.status, want.source_copied, want.inserted_count);
              $display("                 got      status %0d copied %0d literal %0d",
                       status_o, source_copied_o, inserted_count_o);
            end
          end
        end
      end
    end
  end

  // The driver works on the falling edge. A word stays on the port until it
  // is taken; the next one follows at once unless a random gap starts. A
  // register write or a pause waits until every owed result has come back and
  // the settle count has run out, so the parser is surely idle.
  always @(negedge clk_i) begin : driver
    stim_t w;
    logic  hold;
    logic  raise_we;
    hold     = in_valid_i && !in_taken;
    raise_we = 1'b0;
    if (rst_ni && !hold) begin
      if (send_gap != 0) begin
        send_gap--;
      end else if (pending.size() != 0) begin
        w = pending[0];
        if (w.kind == WORD_BYTE) begin
          if (idling_allowed && $urandom_range(5, 0) == 0) begin
            // No word in this cycle; a random gap of further idle cycles may follow.
            send_gap = $urandom_range(9, 0);
          end else begin
            w = pending.pop_front();
            delta_byte_i <= w.data;
            last_byte_i  <= w.last;
            hold = 1'b1;
          end
        end else if (expected_results.size() != 0) begin
          settle = 0;
        end else if (settle < SettleCycles) begin
          settle++;
        end else begin
          settle = 0;
          w = pending.pop_front();
          if (w.kind == WORD_CONFIG) begin
            cfg_wdata_i <= w.data;
            raise_we = 1'b1;
          end
        end
      end
    end
    in_valid_i <= hold;
    cfg_we_i   <= raise_we;
  end

  // The result side stalls in random bursts, whether or not a word is waiting,
  // so stalls land on every stage of the block's work.
  always @(negedge clk_i) begin : receiver
    if (stall_left != 0) begin
      stall_left--;
      out_stall_i <= 1'b1;
    end else if (idling_allowed && $urandom_range(7, 0) == 0) begin
      stall_left = $urandom_range(9, 0);
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // Ends a run in which nothing moves for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QuietLimit) begin
      @(posedge clk_i);
      if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || cfg_we_i)
        quiet = 0;
      else
        quiet++;
    end
    $display("tb failed");
    $finish;
  end

  initial begin : stimulus
    logic [7:0] phase_min;
    int         phase_end;
    clear_scan();
    min_length = MinLenReset;

    // Directed streams, shortest length at its reset value of four.
    // A lone byte is far too short.
    queue_byte(8'h00, 1'b1);
    // Target of 64 KiB met by one copy without operands (size zero means
    // 64 KiB), followed by a zero-length literal.
    queue_byte(8'h7F, 1'b0);
    queue_byte(8'h80, 1'b0);
    queue_byte(8'h80, 1'b0);
    queue_byte(8'h04, 1'b0);
    queue_byte(8'h80, 1'b0);
    queue_byte(8'h00, 1'b1);
    // A copy out of the target with only its low size byte: output matches,
    // but nothing counts as copied from the source.
    queue_byte(8'h00, 1'b0);
    queue_byte(8'h03, 1'b0);
    queue_byte(8'hD0, 1'b0);
    queue_byte(8'h03, 1'b1);
    // The stream stops inside the target size.
    queue_byte(8'h00, 1'b0);
    queue_byte(8'h81, 1'b0);
    queue_byte(8'h80, 1'b0);
    queue_byte(8'h80, 1'b1);
    // One literal byte where two were announced: size mismatch.
    queue_byte(8'h00, 1'b0);
    queue_byte(8'h02, 1'b0);
    queue_byte(8'h01, 1'b0);
    queue_byte(8'hFF, 1'b1);
    // A target size that does not fit the counter.
    queue_byte(8'h00, 1'b0);
    queue_byte(8'hFF, 1'b0);
    queue_byte(8'hFF, 1'b0);
    queue_byte(8'hFF, 1'b0);
    queue_byte(8'hFF, 1'b0);
    queue_byte(8'h7F, 1'b0);
    queue_byte(8'h00, 1'b1);

    // Random phases, each under its own shortest length: no limit, the
    // largest one, two random small ones, and back to the reset value.
    for (int phase_i = 0; phase_i < 5; phase_i++) begin
      case (phase_i)
        0: phase_min = 8'd0;
        1: phase_min = 8'd255;
        4: phase_min = MinLenReset;
        default: phase_min = 8'($urandom_range(16, 1));
      endcase
      queue_word(WORD_CONFIG, phase_min, 1'b0);
      phase_end = bytes_queued + ((phase_i == 1) ? 80 : 230);
      while (bytes_queued < phase_end) begin
        queue_random_stream();
        // Now and then the sender holds back until the block has caught up.
        if (phase_i == 2 && bytes_queued < phase_end && $urandom_range(3, 0) == 0) begin
          queue_word(WORD_DRAIN, 8'h00, 1'b0);
        end
      end
      if (phase_i == 2) queue_word(WORD_DRAIN, 8'h00, 1'b0);
    end

    while (pending.size() != 0 || in_valid_i) @(negedge clk_i);
    while (expected_results.size() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
    if (error_count == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
